// ===== design/text_motion_to_tty_codes_macros.svh =====
// assertion helpers for the file that checks this block
`ifndef TEXT_MOTION_TO_TTY_CODES_MACROS_SVH
`define TEXT_MOTION_TO_TTY_CODES_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define TMTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define TMTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tmtc_pkg.sv =====
package tmtc_pkg;

  // run slots of one job; only the first few carry a variable count
  localparam int NSLOT = 6;
  localparam int NCNT  = 3;
  localparam int NESC  = 2;

  // error codes on a result
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FONT  = 2'd2;

  // one directive
  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] amount;
    logic [7:0]         character;
    logic [11:0]        advance;
  } tmtc_in_t;

  // one output run
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        escaped;
    logic [15:0] repeat_res;
    logic [1:0]  error_code;
    logic        last;
  } tmtc_out_t;

  // classified item: up to six runs, in output order
  typedef struct packed {
    logic [NSLOT-1:0]       mask;
    logic [1:0]             err;
    logic [NSLOT-1:0][7:0]  bytes;
    logic [NESC-1:0]        esc;
    logic [NCNT-1:0][15:0]  cnt;
  } tmtc_job_t;

  // job queue status
  typedef struct packed {
    logic valid;
    logic full;
  } tmtc_qstat_t;

endpackage

// ===== design/text_motion_to_tty_codes.sv =====
// channel   direction   payload      handshake
// item      in          tmtc_in_t    item_valid / item_ready
// result    out         tmtc_out_t   result_valid / result_ready
//
// a beat on item is taken in every cycle while the job queue has room
// each item leaves 0 to 6 result beats, one per cycle from the run sequencer
// in the back while result_ready does not hold the output
// reset clears position, residues, font, queue and sequencer
// result_ready low holds the output; item_ready drops once the queue fills
`include "text_motion_to_tty_codes_macros.svh"

module text_motion_to_tty_codes
  import tmtc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  tmtc_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output tmtc_out_t result
);

  tmtc_qstat_t q_stat;
  tmtc_job_t   wr_job;
  tmtc_job_t   rd_job;
  logic        push;
  logic        q_pop;

  // classify items and keep the typesetting state
  tmtc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .push       (push),
    .job        (wr_job)
  );

  // jobs waiting for the sequencer
  tmtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  // send runs, one per cycle while the output is not held
  tmtc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (rd_job),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // checks
  `TMTC_ASSERT_IMPL(a_pop_nonempty, q_pop, q_stat.valid, "job taken from empty queue")
  `TMTC_ASSERT_NEXT(a_push_lands, push && !q_pop, q_stat.valid, "pushed job not held in queue")
  `TMTC_ASSERT_IMPL(a_repeat_nonzero, result_valid, result.repeat_res != 16'd0, "run with zero count")
  `TMTC_ASSERT_IMPL(a_error_single, result_valid && (result.error_code != ERR_NONE), result.last, "error run not final")

endmodule

// ===== design/tmtc_front.sv =====
module tmtc_front
  import tmtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  tmtc_in_t    item,
  input  tmtc_qstat_t q_stat,
  output logic        push,
  output tmtc_job_t   job
);

  localparam int CHAR_CODES = 128;

  localparam logic [2:0] ACT_HMOVE  = 3'd1;
  localparam logic [2:0] ACT_VMOVE  = 3'd2;
  localparam logic [2:0] ACT_FONT   = 3'd3;
  localparam logic [2:0] ACT_LSPACE = 3'd4;
  localparam logic [2:0] ACT_PRINT  = 3'd5;
  localparam logic [2:0] ACT_HYPHEN = 3'd6;

  localparam logic [1:0] FONT_ROMAN   = 2'd0;
  localparam logic [1:0] FONT_BOLD    = 2'd2;
  localparam logic [1:0] FONT_UNKNOWN = 2'd3;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_US     = 8'h5F;

  localparam logic signed [21:0] SAT_HI = 22'sd524287;
  localparam logic signed [21:0] SAT_LO = -22'sd524288;

  // reciprocals for the constant dividers, rounded down
  localparam logic [16:0] K12 = 17'(2**20 / 12);
  localparam logic [16:0] K20 = 17'(2**20 / 20);

  typedef struct packed {
    logic [15:0] quo;
    logic [4:0]  rem;
  } tmtc_div_t;

  function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
    if (v > SAT_HI) return SAT_HI[19:0];
    if (v < SAT_LO) return SAT_LO[19:0];
    return v[19:0];
  endfunction

  // x / 12: reciprocal product, then one correction step
  function automatic tmtc_div_t div12(input logic [19:0] x);
    logic [36:0] prod;
    logic [16:0] q;
    logic [20:0] r;
    tmtc_div_t   d;
    prod = 37'(x) * 37'(K12);
    q    = prod[36:20];
    r    = 21'(x) - 21'(q) * 21'd12;
    if (r >= 21'd12) begin
      q = q + 17'd1;
      r = r - 21'd12;
    end
    d.quo = q[15:0];
    d.rem = r[4:0];
    return d;
  endfunction

  // x / 20: reciprocal product, then one correction step
  function automatic tmtc_div_t div20(input logic [19:0] x);
    logic [36:0] prod;
    logic [16:0] q;
    logic [20:0] r;
    tmtc_div_t   d;
    prod = 37'(x) * 37'(K20);
    q    = prod[36:20];
    r    = 21'(x) - 21'(q) * 21'd20;
    if (r >= 21'd20) begin
      q = q + 17'd1;
      r = r - 21'd20;
    end
    d.quo = q[15:0];
    d.rem = r[4:0];
    return d;
  endfunction

  // typesetting state
  logic signed [19:0] col_pos, col_pos_next;
  logic signed [19:0] col_res, col_res_next;
  logic signed [19:0] line_res, line_res_next;
  logic [1:0]         font, font_next;

  logic               accept;
  logic [7:0]         chr;
  logic               is_print;
  logic               in_table;
  logic               alnum;
  logic               styled;
  logic               merge;
  logic signed [21:0] amt22, adv22, cp22, cr22, lr22, v22;
  logic signed [21:0] x_line, x_col, rem_c, h, p;
  logic signed [19:0] lsum;
  tmtc_div_t          dl, dc;
  logic [7:0]         col_byte;

  assign item_ready = !q_stat.full;
  assign accept     = item_valid && item_ready;

  // classify the character
  always_comb begin
    chr      = (item.action == ACT_HYPHEN) ? CH_HYPHEN : item.character;
    is_print = (item.action == ACT_PRINT) || (item.action == ACT_HYPHEN);
    in_table = {1'b0, chr} < 9'(CHAR_CODES);
    alnum    = chr inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    styled   = (font != FONT_ROMAN) && alnum;
  end

  // dividends and the two constant dividers
  always_comb begin
    amt22 = 22'(item.amount);
    adv22 = 22'(item.advance);
    cp22  = 22'(col_pos);
    cr22  = 22'(col_res);
    lr22  = 22'(line_res);
    lsum  = sat20(lr22 + amt22);
    v22   = 22'(lsum);
    if (is_print) begin
      x_line = !line_res[19] ? (lr22 + 22'sd5) : (22'sd5 - lr22);
    end else begin
      x_line = !lsum[19] ? (v22 + 22'sd10) : (22'sd9 - v22);
    end
    x_col    = !col_res[19] ? (cr22 + 22'sd6) : (22'sd5 - cr22);
    dl       = div20(x_line[19:0]);
    dc       = div12(x_col[19:0]);
    rem_c    = 22'(dc.rem);
    rem_c    = !col_res[19] ? (rem_c - 22'sd6) : (22'sd5 - rem_c);
    col_byte = col_res[19] ? CH_BS : CH_SP;
    merge    = !styled && (chr == col_byte) && (dc.quo != 16'd0);
  end

  // state update and run list
  always_comb begin
    col_pos_next  = col_pos;
    col_res_next  = col_res;
    line_res_next = line_res;
    font_next     = font;
    job           = '0;
    h             = cr22 + amt22;
    p             = cp22 + amt22;
    case (item.action)
      ACT_HMOVE: begin
        if (p < 22'sd0) begin
          h = h - p;
          p = '0;
        end
        col_res_next = sat20(h);
        col_pos_next = sat20(p);
      end
      ACT_VMOVE: begin
        line_res_next = lsum;
      end
      ACT_FONT: begin
        if (item.amount >= 16'sd0 && item.amount <= 16'sd2) begin
          font_next = item.amount[1:0];
        end else begin
          font_next = FONT_UNKNOWN;
        end
      end
      ACT_LSPACE: begin
        col_pos_next = '0;
        col_res_next = '0;
        if (!lsum[19]) begin
          line_res_next = 20'(dl.rem) - 20'sd10;
          job.bytes[0]  = CH_NL;
          job.cnt[0]    = dl.quo;
          job.mask[0]   = dl.quo != 16'd0;
        end else begin
          line_res_next = 20'sd9 - 20'(dl.rem);
          job.bytes[0]  = CH_CR;
          job.cnt[0]    = 16'd1;
          job.mask[0]   = 1'b1;
          job.bytes[1]  = CH_7;
          job.esc[1]    = 1'b1;
          job.cnt[1]    = dl.quo;
          job.mask[1]   = dl.quo != 16'd0;
        end
      end
      ACT_PRINT, ACT_HYPHEN: begin
        if (!in_table || (styled && font == FONT_UNKNOWN)) begin
          // single error run, state untouched
          job.err     = !in_table ? ERR_RANGE : ERR_FONT;
          job.cnt[0]  = 16'd1;
          job.mask[0] = 1'b1;
        end else begin
          line_res_next = '0;
          col_res_next  = sat20(rem_c + adv22 - 22'sd12);
          col_pos_next  = sat20(cp22 + adv22);
          // vertical settle
          job.bytes[0]  = line_res[19] ? CH_7 : CH_B;
          job.esc[0]    = 1'b1;
          job.cnt[0]    = dl.quo;
          job.mask[0]   = dl.quo != 16'd0;
          job.bytes[1]  = line_res[19] ? CH_8 : CH_9;
          job.esc[1]    = 1'b1;
          job.cnt[1]    = 16'd1;
          job.mask[1]   = dl.rem >= 5'd10;
          // horizontal settle, absorbing a matching printed byte
          job.bytes[2]  = col_byte;
          job.cnt[2]    = dc.quo + {15'd0, merge};
          job.mask[2]   = dc.quo != 16'd0;
          // overstrike or underline
          job.bytes[3]  = (font == FONT_BOLD) ? chr : CH_US;
          job.mask[3]   = styled;
          job.bytes[4]  = CH_BS;
          job.mask[4]   = styled;
          job.bytes[5]  = chr;
          job.mask[5]   = !merge;
        end
      end
      default: begin
      end
    endcase
    push = accept && (job.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      col_res  <= '0;
      line_res <= '0;
      font     <= FONT_ROMAN;
    end else if (accept && !(is_print && job.err != ERR_NONE)) begin
      col_pos  <= col_pos_next;
      col_res  <= col_res_next;
      line_res <= line_res_next;
      font     <= font_next;
    end
  end

endmodule

// ===== design/tmtc_queue.sv =====
module tmtc_queue
  import tmtc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tmtc_job_t   wr_job,
  input  logic        pop,
  output tmtc_job_t   rd_job,
  output tmtc_qstat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tmtc_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign rd_job       = mem[rd_ptr];
  assign q_stat.valid = count != '0;
  assign q_stat.full  = count == CW'(DEPTH);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/tmtc_back.sv =====
module tmtc_back
  import tmtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tmtc_job_t   job,
  input  tmtc_qstat_t q_stat,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output tmtc_out_t   result
);

  tmtc_job_t                cur;
  logic                     cur_valid;
  logic [NSLOT-1:0]         done;
  logic [NSLOT-1:0]         pending;
  logic [NSLOT-1:0]         pick;
  logic [NSLOT-1:0]         slot_esc;
  logic [NSLOT-1:0][15:0]   slot_cnt;
  logic                     emit;
  logic                     is_last;
  tmtc_out_t                res_next;

  // lowest run still to send
  always_comb begin
    pending = cur.mask & ~done;
    pick    = pending & (~pending + NSLOT'(1));
    is_last = (pending & ~pick) == '0;
    emit    = cur_valid && (!result_valid || result_ready);
    pop     = q_stat.valid && (!cur_valid || (emit && is_last));
  end

  // select the picked slot
  always_comb begin
    slot_esc = '0;
    slot_esc[NESC-1:0] = cur.esc;
    for (int i = 0; i < NSLOT; i++) begin
      slot_cnt[i] = 16'd1;
    end
    for (int i = 0; i < NCNT; i++) begin
      slot_cnt[i] = cur.cnt[i];
    end
    res_next            = '0;
    res_next.error_code = cur.err;
    res_next.last       = is_last;
    for (int i = 0; i < NSLOT; i++) begin
      if (pick[i]) begin
        res_next.out_byte   = cur.bytes[i];
        res_next.escaped    = slot_esc[i];
        res_next.repeat_res = slot_cnt[i];
      end
    end
  end

  // current job and sent-slot mask
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      done      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      done      <= '0;
    end else if (emit) begin
      cur_valid <= !is_last;
      done      <= done | pick;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

endmodule

// ===== test/tb_text_motion_to_tty_codes.sv =====
`timescale 1ns / 100ps

module tb_text_motion_to_tty_codes;
  import tmtc_pkg::*;

  // directive codes on the action field
  typedef enum logic [2:0] {
    ACT_IGNORE = 3'd0,
    ACT_HMOVE  = 3'd1,
    ACT_VMOVE  = 3'd2,
    ACT_FONT   = 3'd3,
    ACT_LINE   = 3'd4,
    ACT_CHAR   = 3'd5,
    ACT_HYPHEN = 3'd6,
    ACT_SPARE  = 3'd7
  } directive_e;

  typedef enum logic [1:0] {
    FONT_ROMAN   = 2'd0,
    FONT_ITALIC  = 2'd1,
    FONT_BOLD    = 2'd2,
    FONT_UNKNOWN = 2'd3
  } font_e;

  // terminal bytes
  localparam logic [7:0] CH_NL        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_SP        = 8'h20;
  localparam logic [7:0] CH_UNDER     = "_";
  localparam logic [7:0] CH_HYPHEN    = "-";
  localparam logic [7:0] ESC_LINE_FWD = "B";
  localparam logic [7:0] ESC_LINE_REV = "7";
  localparam logic [7:0] ESC_HALF_FWD = "9";
  localparam logic [7:0] ESC_HALF_REV = "8";

  localparam int     CHAR_CODES   = 128;
  localparam int     LINE_UNITS   = 20;
  localparam int     COL_UNITS    = 12;
  localparam longint SAT_HI       = 524287;
  localparam longint SAT_LO       = -524288;
  localparam int     RANDOM_ITEMS = 480;

  typedef struct {
    tmtc_in_t dir;
    int       gap;
    bit       drain;
  } queued_directive_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  tmtc_in_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  tmtc_out_t result;

  text_motion_to_tty_codes uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  queued_directive_t directives_pending[$];
  tmtc_out_t         tty_runs_due[$];
  tmtc_out_t         item_runs[$];

  int n_queued = 0;
  int n_useful = 0;
  int n_taken  = 0;
  int n_errors = 0;
  bit sender_calm = 1'b0;

  // terminal state tracked alongside the block
  longint pos_col  = 0;
  longint res_col  = 0;
  longint res_line = 0;
  font_e  font_now = FONT_ROMAN;

  function automatic longint sat20(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // append a run, merging with the previous one when byte and escape match
  function automatic void add_run(input logic [7:0] b, input logic esc, input longint cnt);
    tmtc_out_t r;
    longint    sum;
    if (cnt <= 0) return;
    if (item_runs.size() != 0 && item_runs[item_runs.size()-1].out_byte == b &&
        item_runs[item_runs.size()-1].escaped == esc) begin
      r = item_runs.pop_back();
      sum = r.repeat_res + cnt;
    end else begin
      r = '0;
      r.out_byte = b;
      r.escaped = esc;
      r.error_code = ERR_NONE;
      sum = cnt;
    end
    r.repeat_res = (sum > 65535) ? 16'hffff : sum[15:0];
    item_runs.push_back(r);
  endfunction

  // work out the terminal runs of one directive and queue them as due
  function automatic void predict_tty_runs(input tmtc_in_t d);
    longint     amt, adv, h, p, v, n;
    logic [7:0] c;
    bit         styled;
    tmtc_out_t  r;
    amt = $signed(d.amount);
    adv = d.advance;
    item_runs.delete();
    case (directive_e'(d.action))
      ACT_HMOVE: begin
        h = res_col + amt;
        p = pos_col + amt;
        // position clamps at the left margin, the residue keeps the rest
        if (p < 0) begin
          h = h - p;
          p = 0;
        end
        res_col = sat20(h);
        pos_col = sat20(p);
      end
      ACT_VMOVE: begin
        res_line = sat20(res_line + amt);
      end
      ACT_FONT: begin
        font_now = (amt >= 0 && amt <= 2) ? font_e'(amt[1:0]) : FONT_UNKNOWN;
      end
      ACT_LINE: begin
        pos_col = 0;
        res_col = 0;
        v = sat20(res_line + amt);
        if (v >= 0) begin
          n = (v + 10) / LINE_UNITS;
          v = v - n * LINE_UNITS;
          add_run(CH_NL, 1'b0, n);
        end else begin
          add_run(CH_CR, 1'b0, 1);
          n = (-v + 9) / LINE_UNITS;
          v = v + n * LINE_UNITS;
          add_run(ESC_LINE_REV, 1'b1, n);
        end
        res_line = v;
      end
      ACT_CHAR, ACT_HYPHEN: begin
        c = (directive_e'(d.action) == ACT_HYPHEN) ? CH_HYPHEN : d.character;
        styled = (font_now != FONT_ROMAN) && is_alnum(c);
        if (c >= CHAR_CODES || (styled && font_now == FONT_UNKNOWN)) begin
          // error beat, state untouched
          r = '0;
          r.repeat_res = 16'd1;
          r.error_code = (c >= CHAR_CODES) ? ERR_RANGE : ERR_FONT;
          item_runs.push_back(r);
        end else begin
          // settle vertical residue, rounding to half lines
          if (res_line >= 0) begin
            v = res_line + 5;
            add_run(ESC_LINE_FWD, 1'b1, v / LINE_UNITS);
            if ((v % LINE_UNITS) >= 10) add_run(ESC_HALF_FWD, 1'b1, 1);
          end else begin
            v = -(res_line - 5);
            add_run(ESC_LINE_REV, 1'b1, v / LINE_UNITS);
            if ((v % LINE_UNITS) >= 10) add_run(ESC_HALF_REV, 1'b1, 1);
          end
          res_line = 0;
          // settle horizontal residue in whole columns
          if (res_col >= 0) begin
            n = (res_col + 6) / COL_UNITS;
            res_col = res_col - n * COL_UNITS;
            add_run(CH_SP, 1'b0, n);
          end else begin
            n = (-res_col + 5) / COL_UNITS;
            res_col = res_col + n * COL_UNITS;
            add_run(CH_BS, 1'b0, n);
          end
          // bold overstrikes, italic underlines
          if (styled) begin
            add_run((font_now == FONT_BOLD) ? c : CH_UNDER, 1'b0, 1);
            add_run(CH_BS, 1'b0, 1);
          end
          add_run(c, 1'b0, 1);
          res_col = sat20(res_col + adv - COL_UNITS);
          pos_col = sat20(pos_col + adv);
        end
      end
      default: ;
    endcase
    if (item_runs.size() != 0) begin
      r = item_runs.pop_back();
      r.last = 1'b1;
      item_runs.push_back(r);
    end
    foreach (item_runs[i]) tty_runs_due.push_back(item_runs[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    n_errors++;
    $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic queue_directive(input directive_e act, input logic signed [15:0] amt,
                                 input logic [7:0] ch, input logic [11:0] adv,
                                 input bit drain);
    queued_directive_t e;
    e.dir.action = act;
    e.dir.amount = amt;
    e.dir.character = ch;
    e.dir.advance = adv;
    e.gap = sender_calm ? 0 : $urandom_range(0, 8);
    e.drain = drain;
    directives_pending.push_back(e);
    n_queued++;
    if (act != ACT_IGNORE && act != ACT_SPARE) n_useful++;
  endtask

  // driver: present queued directives, predict on each accepted beat
  int gap_left = 0;
  always @(posedge clk) begin
    queued_directive_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (item_valid && item_ready) begin
        predict_tty_runs(item);
        n_taken++;
      end
      if (!item_valid || item_ready) begin
        if (gap_left != 0) begin
          item_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (directives_pending.size() != 0 &&
                     !(directives_pending[0].drain && tty_runs_due.size() != 0)) begin
          nxt = directives_pending.pop_front();
          item <= nxt.dir;
          item_valid <= 1'b1;
          gap_left <= nxt.gap;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result beats in order, stall at random
  int  stall_left = 0;
  int  phase_left = 0;
  bit  receiver_calm = 1'b0;
  always @(posedge clk) begin
    tmtc_out_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (tty_runs_due.size() == 0) begin
          report_mismatch("beat with nothing due", {8'd0, result.out_byte}, 16'd0);
        end else begin
          want = tty_runs_due.pop_front();
          if (result.out_byte !== want.out_byte)
            report_mismatch("out_byte", {8'd0, result.out_byte}, {8'd0, want.out_byte});
          if (result.escaped !== want.escaped)
            report_mismatch("escaped", {15'd0, result.escaped}, {15'd0, want.escaped});
          if (result.repeat_res !== want.repeat_res)
            report_mismatch("repeat_res", result.repeat_res, want.repeat_res);
          if (result.error_code !== want.error_code)
            report_mismatch("error_code", {14'd0, result.error_code},
                            {14'd0, want.error_code});
          if (result.last !== want.last)
            report_mismatch("last", {15'd0, result.last}, {15'd0, want.last});
        end
        if (phase_left == 0) begin
          receiver_calm = ($urandom_range(0, 2) == 0);
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        stall_left = receiver_calm ? 0 : $urandom_range(0, 8);
      end
      if (stall_left != 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int                 seg_left;
    int                 pick;
    int                 n_target;
    directive_e         act;
    logic signed [15:0] amt;
    logic [7:0]         ch;
    logic [11:0]        adv;

    // directed: fonts, errors, extremes, merged runs, no-output cases
    queue_directive(ACT_CHAR, 16'sd0, "A", 12'd12, 1'b0);
    queue_directive(ACT_HMOVE, 16'sd30, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_VMOVE, 16'sd10, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, "b", 12'd0, 1'b0);
    queue_directive(ACT_FONT, 16'sd1, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, "x", 12'd4095, 1'b0);
    queue_directive(ACT_FONT, 16'sd2, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, "7", 12'd12, 1'b0);
    queue_directive(ACT_FONT, 16'sd7, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, "Q", 12'd12, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, ".", 12'd12, 1'b0);
    queue_directive(ACT_FONT, 16'sd0, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, 8'd200, 12'd12, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, 8'd127, 12'd12, 1'b0);
    queue_directive(ACT_HYPHEN, 16'sd0, 8'd255, 12'd12, 1'b0);
    queue_directive(ACT_VMOVE, -16'sd32768, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_CHAR, 16'sd0, 8'd0, 12'd12, 1'b0);
    queue_directive(ACT_HMOVE, -16'sd32768, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_LINE, 16'sd32767, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_LINE, -16'sd32768, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_LINE, 16'sd0, 8'd0, 12'd0, 1'b0);
    queue_directive(ACT_IGNORE, -16'sd1, 8'd255, 12'd4095, 1'b0);
    queue_directive(ACT_SPARE, -16'sd1, 8'd255, 12'd4095, 1'b0);
    queue_directive(ACT_HMOVE, 16'sd24, 8'd0, 12'd0, 1'b0);
    // sender waits for every run so far before this one
    queue_directive(ACT_CHAR, 16'sd0, " ", 12'd12, 1'b1);

    // random: mostly well-formed text with moves, some noise and saturation bursts
    n_target = n_useful + RANDOM_ITEMS;
    seg_left = 0;
    while (n_useful < n_target) begin
      if (seg_left == 0) begin
        sender_calm = ($urandom_range(0, 2) == 0);
        seg_left = $urandom_range(10, 50);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      amt = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 240) - 120) : 16'($urandom());
      ch = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(32, 126)) :
           ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127)) : 8'($urandom());
      adv = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, 40)) : 12'($urandom());
      if (pick < 2) begin
        // drive one residue into saturation, then print
        act = ($urandom_range(0, 1) != 0) ? ACT_HMOVE : ACT_VMOVE;
        amt = ($urandom_range(0, 1) != 0) ? 16'sd32767 : -16'sd32768;
        repeat (18) queue_directive(act, amt, ch, adv, 1'b0);
        queue_directive(ACT_CHAR, 16'sd0, 8'($urandom_range(32, 126)), adv, 1'b0);
      end else begin
        if (pick < 8) begin
          act = directive_e'($urandom_range(0, 7));
          amt = 16'($urandom());
          ch = 8'($urandom());
          adv = 12'($urandom());
        end else if (pick < 50) begin
          act = ($urandom_range(0, 19) == 0) ? ACT_HYPHEN : ACT_CHAR;
        end else if (pick < 62) begin
          act = ACT_HMOVE;
        end else if (pick < 72) begin
          act = ACT_VMOVE;
        end else if (pick < 82) begin
          act = ACT_FONT;
          if ($urandom_range(0, 19) < 17) amt = 16'($urandom_range(0, 2));
        end else begin
          act = ACT_LINE;
          if ($urandom_range(0, 9) < 8) amt = 16'($urandom_range(0, 70) - 10);
        end
        // sender holds off now and then until all runs are back
        queue_directive(act, amt, ch, adv, (n_useful % 120) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_taken != n_queued) @(posedge clk);
    while (tty_runs_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (n_errors == 0)
      $display("text_motion_to_tty_codes test passed");
    else
      $display("text_motion_to_tty_codes test failed");
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("text_motion_to_tty_codes test failed");
    $finish;
  end

endmodule
